FILE: rtl/pictl_pkg.sv
// Shared constants, types, microcode and saturating arithmetic for the PI controller.
package pictl_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int GAIN_W = DATA_W - 1;
  localparam int IDX_W  = 3;
  localparam int STEP_W = 4;
  localparam int PROD_W = 2 * DATA_W;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic [STEP_W-1:0]        step_t;

  localparam fx_t   FX_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fx_t   FX_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
  localparam gain_t TRACK_RESET = gain_t'(1) << FRAC_W;
  localparam gain_t TIMER_MAX   = {GAIN_W{1'b1}};

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_TRACKING_RATE = 3'd2,
    REG_DRIVE_MIN     = 3'd3,
    REG_DRIVE_MAX     = 3'd4
  } reg_idx_t;

  // Operand pairs presented to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_KP_ERR,
    MUL_KI_ERR,
    MUL_FX_DT,
    MUL_DIFF_DT,
    MUL_FX_TRACK
  } mul_sel_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_PROP,
    ALU_DEMAND,
    ALU_DIFF,
    ALU_GAIN,
    ALU_COMMIT,
    ALU_PRELOAD
  } alu_op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_PRELOAD,
    COND_HOLD,
    COND_JUMP,
    COND_END
  } cond_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
    cond_t    cond;
    step_t    target;
  } uword_t;

  localparam step_t STEP_ENTRY = step_t'(0);
  localparam step_t STEP_OUT   = step_t'(10);
  localparam step_t STEP_PRE   = step_t'(11);

  // The multiplier has two register stages, the raw product and the rounded result, so a
  // product issued in one step is usable by the ALU only once both have loaded.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    begin
      w = '{MUL_KP_ERR, ALU_NOP, COND_END, STEP_OUT};
      case (step)
        step_t'(0):  w = '{MUL_KP_ERR,   ALU_NOP,     COND_PRELOAD, STEP_PRE};
        step_t'(1):  w = '{MUL_KI_ERR,   ALU_NOP,     COND_HOLD,    STEP_OUT};
        step_t'(2):  w = '{MUL_KI_ERR,   ALU_PROP,    COND_NEXT,    STEP_OUT};
        step_t'(3):  w = '{MUL_FX_DT,    ALU_DEMAND,  COND_NEXT,    STEP_OUT};
        step_t'(4):  w = '{MUL_FX_DT,    ALU_DIFF,    COND_NEXT,    STEP_OUT};
        step_t'(5):  w = '{MUL_DIFF_DT,  ALU_GAIN,    COND_NEXT,    STEP_OUT};
        step_t'(6):  w = '{MUL_DIFF_DT,  ALU_NOP,     COND_NEXT,    STEP_OUT};
        step_t'(7):  w = '{MUL_FX_TRACK, ALU_NOP,     COND_NEXT,    STEP_OUT};
        step_t'(8):  w = '{MUL_FX_TRACK, ALU_NOP,     COND_NEXT,    STEP_OUT};
        step_t'(9):  w = '{MUL_FX_TRACK, ALU_COMMIT,  COND_NEXT,    STEP_OUT};
        step_t'(10): w = '{MUL_KP_ERR,   ALU_NOP,     COND_END,     STEP_OUT};
        step_t'(11): w = '{MUL_KP_ERR,   ALU_PRELOAD, COND_JUMP,    STEP_OUT};
        default:     w = '{MUL_KP_ERR,   ALU_NOP,     COND_END,     STEP_OUT};
      endcase
      return w;
    end
  endfunction

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic signed [DATA_W:0] s;
    begin
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
        return s[DATA_W] ? FX_MIN : FX_MAX;
      end
      return s[DATA_W-1:0];
    end
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    logic signed [DATA_W:0] s;
    begin
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
        return s[DATA_W] ? FX_MIN : FX_MAX;
      end
      return s[DATA_W-1:0];
    end
  endfunction

  // The lower limit is tested first, which settles inverted limits.
  function automatic fx_t clamp(input fx_t x, input fx_t lo, input fx_t hi);
    begin
      if (x < lo) begin
        return lo;
      end
      if (x > hi) begin
        return hi;
      end
      return x;
    end
  endfunction

endpackage

FILE: rtl/pictl_if.sv
// Handshake channel interfaces for commands, results and register writes.
interface pictl_in_if;
  import pictl_pkg::*;
  logic valid;
  logic ready;
  logic action;
  fx_t  error_value;
  fx_t  feedforward;
  fx_t  time_step;
  fx_t  preload_value;
  modport source(output valid, action, error_value, feedforward, time_step, preload_value,
                 input ready);
  modport sink(input valid, action, error_value, feedforward, time_step, preload_value,
               output ready);
endinterface

interface pictl_out_if;
  import pictl_pkg::*;
  logic  valid;
  logic  ready;
  fx_t   drive;
  fx_t   raw_demand;
  fx_t   integrator_value;
  logic  saturated;
  gain_t saturated_time;
  modport source(output valid, drive, raw_demand, integrator_value, saturated, saturated_time,
                 input ready);
  modport sink(input valid, drive, raw_demand, integrator_value, saturated, saturated_time,
               output ready);
endinterface

interface pictl_cfg_if;
  import pictl_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/pi_controller_antiwindup_top.sv
// PI controller with back-calculation anti-windup, driven by a microcoded sequencer.
//
// Each command is run by a short microprogram over one shared 32x32 multiplier whose
// product passes a rounding and saturation register before use, so a chained product
// waits on the product register and then on the rounding register. A regulation step runs the
// whole microprogram, while a preload or a step with a time step of zero or less skips most
// of it. A new command is accepted in the cycle after the result is loaded into the
// output register, which holds the result until taken while the next command runs.
// Register writes are always ready and are meant for when the block is idle.
module pi_controller_antiwindup_top (
  input  logic         clk,
  input  logic         rst,
  pictl_in_if.sink     cmd,
  pictl_out_if.source  result,
  pictl_cfg_if.sink    cfg
);
  import pictl_pkg::*;

  gain_t prop_gain;
  gain_t integral_gain;
  gain_t tracking_rate;
  fx_t   drive_min;
  fx_t   drive_max;

  logic   busy;
  step_t  step;
  uword_t uw;

  logic op_action;
  fx_t  op_error;
  fx_t  op_ff;
  fx_t  op_dt;
  fx_t  op_pre;
  logic op_hold;

  fx_t               mul_a;
  fx_t               mul_b;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [PROD_W-1:0] prod_mag;
  logic              prod_neg;
  logic [PROD_W-1:0] rnd;
  logic              rnd_over;
  fx_t               rnd_q;
  fx_t               fx_prod;

  fx_t acc;
  fx_t diff;
  fx_t demand;
  fx_t integ_sum;

  fx_t               integrator;
  fx_t               last_drive;
  fx_t               last_raw_demand;
  logic              sat_flag;
  gain_t             sat_timer;
  logic [GAIN_W:0]   timer_sum;
  gain_t             timer_next;

  logic  res_valid;
  logic  res_load;
  fx_t   res_drive;
  fx_t   res_raw;
  fx_t   res_integ;
  logic  res_sat;
  gain_t res_time;

  assign uw        = ucode(step);
  assign cmd.ready = !busy;
  assign cfg.ready = 1'b1;
  assign op_hold   = op_dt[DATA_W-1] || (op_dt == '0);
  assign res_load  = busy && (uw.cond == COND_END) && (!res_valid || result.ready);

  assign result.valid            = res_valid;
  assign result.drive            = res_drive;
  assign result.raw_demand       = res_raw;
  assign result.integrator_value = res_integ;
  assign result.saturated        = res_sat;
  assign result.saturated_time   = res_time;

  // Multiplier operand selection and sign-magnitude split.
  always_comb begin
    case (uw.mul_sel)
      MUL_KP_ERR: begin
        mul_a = {1'b0, prop_gain};
        mul_b = op_error;
      end
      MUL_KI_ERR: begin
        mul_a = {1'b0, integral_gain};
        mul_b = op_error;
      end
      MUL_FX_DT: begin
        mul_a = fx_prod;
        mul_b = op_dt;
      end
      MUL_DIFF_DT: begin
        mul_a = diff;
        mul_b = op_dt;
      end
      MUL_FX_TRACK: begin
        mul_a = fx_prod;
        mul_b = {1'b0, tracking_rate};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mag_a = mul_a[DATA_W-1] ? DATA_W'(-mul_a) : DATA_W'(mul_a);
    mag_b = mul_b[DATA_W-1] ? DATA_W'(-mul_b) : DATA_W'(mul_b);
  end

  // Round half away from zero at the binary point, then saturate.
  always_comb begin
    rnd      = prod_mag + (PROD_W'(1) << (FRAC_W - 1));
    rnd_over = |rnd[PROD_W-1:FRAC_W+DATA_W-1];
    if (prod_neg) begin
      rnd_q = rnd_over ? FX_MIN : -fx_t'(rnd[FRAC_W+DATA_W-1:FRAC_W]);
    end else begin
      rnd_q = rnd_over ? FX_MAX : fx_t'(rnd[FRAC_W+DATA_W-1:FRAC_W]);
    end
  end

  always_comb begin
    demand    = sat_add(acc, op_ff);
    integ_sum = sat_add(acc, fx_prod);
    timer_sum = (GAIN_W+1)'(sat_timer) + (GAIN_W+1)'(op_dt[GAIN_W-1:0]);
    timer_next = timer_sum[GAIN_W] ? TIMER_MAX : timer_sum[GAIN_W-1:0];
  end

  // Datapath work registers.
  always_ff @(posedge clk) begin
    prod_mag <= PROD_W'(mag_a) * PROD_W'(mag_b);
    prod_neg <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
    fx_prod  <= rnd_q;
    if (cmd.valid && cmd.ready) begin
      op_action <= cmd.action;
      op_error  <= cmd.error_value;
      op_ff     <= cmd.feedforward;
      op_dt     <= cmd.time_step;
      op_pre    <= cmd.preload_value;
    end
    if (busy) begin
      case (uw.alu_op)
        ALU_PROP: acc  <= sat_add(fx_prod, integrator);
        ALU_DIFF: diff <= sat_sub(last_drive, last_raw_demand);
        ALU_GAIN: acc  <= sat_add(integrator, fx_prod);
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      step            <= STEP_ENTRY;
      res_valid       <= 1'b0;
      integrator      <= '0;
      last_drive      <= '0;
      last_raw_demand <= '0;
      sat_flag        <= 1'b0;
      sat_timer       <= '0;
      prop_gain       <= '0;
      integral_gain   <= '0;
      tracking_rate   <= TRACK_RESET;
      drive_min       <= '0;
      drive_max       <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_PROP_GAIN:     prop_gain     <= cfg.data[GAIN_W-1:0];
          REG_INTEGRAL_GAIN: integral_gain <= cfg.data[GAIN_W-1:0];
          REG_TRACKING_RATE: tracking_rate <= cfg.data[GAIN_W-1:0];
          REG_DRIVE_MIN:     drive_min     <= fx_t'(cfg.data);
          REG_DRIVE_MAX:     drive_max     <= fx_t'(cfg.data);
          default: ;
        endcase
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      if (cmd.valid && cmd.ready) begin
        busy <= 1'b1;
        step <= STEP_ENTRY;
      end

      if (busy) begin
        case (uw.alu_op)
          ALU_DEMAND: begin
            last_raw_demand <= demand;
            last_drive      <= clamp(demand, drive_min, drive_max);
          end
          ALU_COMMIT: begin
            integrator <= clamp(integ_sum, drive_min, drive_max);
            sat_flag   <= (last_drive != last_raw_demand);
            sat_timer  <= (last_drive != last_raw_demand) ? timer_next : '0;
          end
          ALU_PRELOAD: begin
            integrator      <= clamp(op_pre, drive_min, drive_max);
            last_drive      <= clamp(op_pre, drive_min, drive_max);
            last_raw_demand <= clamp(op_pre, drive_min, drive_max);
            sat_flag        <= 1'b0;
            sat_timer       <= '0;
          end
          default: ;
        endcase

        case (uw.cond)
          COND_NEXT:    step <= step + step_t'(1);
          COND_PRELOAD: step <= op_action ? uw.target : step + step_t'(1);
          COND_HOLD:    step <= op_hold ? uw.target : step + step_t'(1);
          COND_JUMP:    step <= uw.target;
          COND_END: begin
            // The finished result waits here until the output register is free.
            if (res_load) begin
              busy      <= 1'b0;
              res_drive <= last_drive;
              res_raw   <= last_raw_demand;
              res_integ <= integrator;
              res_sat   <= sat_flag;
              res_time  <= sat_timer;
            end
          end
          default: step <= step + step_t'(1);
        endcase
      end
    end
  end

  a_result_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(busy))
    else $error("result appeared without a running program");

  a_sat_means_clamped: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |-> (result.drive != result.raw_demand))
    else $error("saturated result with drive equal to raw demand");

  a_timer_cleared: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.saturated) |-> (result.saturated_time == '0))
    else $error("saturation time nonzero while not saturated");

endmodule
